### rtl/tcre_pkg.sv
// Shared types and constants of the text console region engine.
`timescale 1ns / 1ps
package tcre_pkg;

  localparam int CELL_COUNT = 8192;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int MAX_SPAN   = 128;

  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_SCROLL = 3'd2;
  localparam logic [2:0] OP_FILL   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] CFG_ROW_PITCH     = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_COLUMN = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_ROW    = 3'd2;
  localparam logic [2:0] CFG_REGION_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_REGION_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_ATTRIBUTE     = 3'd5;

  localparam logic [7:0] BLANK_CHAR = 8'h20;

  typedef struct packed {
    logic load;
    logic put_wr;
    logic place;
    logic cell_adr;
    logic copy_rd;
    logic copy_wr;
    logic cell_rd;
    logic cell_wr;
    logic read_rd;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic place_scroll;
    logic cell_last;
  } dp_stat_t;

endpackage

### rtl/tcre_ctrl.sv
// Controller state machine of the text console region engine.
`timescale 1ns / 1ps
module tcre_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_operation,
  input  tcre_pkg::dp_stat_t stat,
  output tcre_pkg::ctl_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_PUT, S_PLACE, S_COPY_ADR, S_COPY_RD, S_COPY_WR,
    S_CELL_ADR, S_CELL_RD, S_CELL_WR, S_READ, S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_operation)
            tcre_pkg::OP_PUT:    state_nxt = S_PUT;
            tcre_pkg::OP_SET:    state_nxt = S_PLACE;
            tcre_pkg::OP_SCROLL: state_nxt = S_COPY_ADR;
            tcre_pkg::OP_FILL:   state_nxt = S_CELL_ADR;
            tcre_pkg::OP_READ:   state_nxt = S_READ;
            default:             state_nxt = S_FIN;
          endcase
        end
      end
      S_PUT:      state_nxt = S_PLACE;
      S_PLACE:    state_nxt = stat.place_scroll ? S_COPY_ADR : S_FIN;
      S_COPY_ADR: state_nxt = S_COPY_RD;
      S_COPY_RD:  state_nxt = S_COPY_WR;
      S_COPY_WR:  state_nxt = stat.cell_last ? S_CELL_ADR : S_COPY_ADR;
      S_CELL_ADR: state_nxt = S_CELL_RD;
      S_CELL_RD:  state_nxt = S_CELL_WR;
      S_CELL_WR:  state_nxt = stat.cell_last ? S_FIN : S_CELL_ADR;
      S_READ:     state_nxt = S_FIN;
      S_FIN:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.put_wr   = (state_r == S_PUT);
    cmd.place    = (state_r == S_PLACE);
    cmd.cell_adr = (state_r == S_CELL_ADR) || (state_r == S_COPY_ADR);
    cmd.copy_rd  = (state_r == S_COPY_RD);
    cmd.copy_wr  = (state_r == S_COPY_WR);
    cmd.cell_rd  = (state_r == S_CELL_RD);
    cmd.cell_wr  = (state_r == S_CELL_WR);
    cmd.read_rd  = (state_r == S_READ);
    cmd.finish   = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("Accepted request did not start work.");

  a_fin_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (state_r == S_IDLE))
    else $error("Finish did not return to idle.");

  a_rd_after_adr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL_RD) |-> ($past(state_r) == S_CELL_ADR))
    else $error("Cell read without address phase.");

endmodule

### rtl/tcre_dpath.sv
// Datapath of the text console region engine: registers, stores and address logic.
`timescale 1ns / 1ps
module tcre_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  tcre_pkg::ctl_cmd_t cmd,
  output tcre_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [2:0]         in_operation,
  input  logic [7:0]         in_character,
  input  logic signed [8:0]  in_column,
  input  logic signed [8:0]  in_row,
  input  logic signed [7:0]  in_shift_columns,
  input  logic signed [7:0]  in_shift_rows,
  input  logic [12:0]        in_cell_address,
  output logic               out_valid,
  output logic [6:0]         out_cursor_column,
  output logic [6:0]         out_cursor_row,
  output logic [7:0]         out_read_character,
  output logic [7:0]         out_read_attribute
);

  localparam int AW = tcre_pkg::ADDR_W;

  logic [7:0] row_pitch_r, region_width_r, region_height_r, attribute_r;
  logic [6:0] origin_column_r, origin_row_r;
  logic [6:0] cursor_col_r, cursor_row_r;

  logic [2:0]         op_r;
  logic [7:0]         char_r;
  logic signed [9:0]  x_r, y_r;
  logic signed [8:0]  hs_r;
  logic signed [10:0] vs_r;
  logic               fill_r;
  logic [AW-1:0]      rd_cell_r;
  logic [7:0]         rcnt_r, ccnt_r;
  logic [AW-1:0]      dst_addr_r, src_addr_r;
  logic               src_in_r;
  logic [7:0]         rd_char_r, rd_attr_r;
  logic [7:0]         sh_char_r, sh_attr_r;

  logic               out_valid_r;
  logic [6:0]         out_col_r, out_row_r;
  logic [7:0]         out_rc_r, out_ra_r;

  logic [7:0] char_mem [tcre_pkg::CELL_COUNT];
  logic [7:0] attr_mem [tcre_pkg::CELL_COUNT];
  logic [7:0] shadow_char [tcre_pkg::CELL_COUNT];
  logic [7:0] shadow_attr [tcre_pkg::CELL_COUNT];

  logic [7:0] w_eff, h_eff;
  logic [7:0] cur_r, cur_c;
  logic signed [11:0] sr, sc;
  logic       src_in;
  logic [AW-1:0] dst_addr, src_addr, cur_addr;
  logic signed [9:0]  nx;
  logic signed [10:0] ny;
  logic [6:0]  fy;
  logic        need_scroll;
  logic signed [10:0] vs_new;
  logic        cell_last;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] orow, input logic [7:0] r,
                                              input logic [7:0] pitch, input logic [6:0] ocol,
                                              input logic [7:0] c);
    logic [8:0]  row_sum;
    logic [16:0] prod;
    logic [16:0] full;
    row_sum = 9'(orow) + 9'(r);
    prod    = 17'(row_sum) * 17'(pitch);
    full    = prod + 17'(ocol) + 17'(c);
    return full[AW-1:0];
  endfunction

  always_comb begin
    if (region_width_r == 8'd0) begin
      w_eff = 8'd1;
    end else if (region_width_r > 8'(tcre_pkg::MAX_SPAN)) begin
      w_eff = 8'(tcre_pkg::MAX_SPAN);
    end else begin
      w_eff = region_width_r;
    end
    if (region_height_r == 8'd0) begin
      h_eff = 8'd1;
    end else if (region_height_r > 8'(tcre_pkg::MAX_SPAN)) begin
      h_eff = 8'(tcre_pkg::MAX_SPAN);
    end else begin
      h_eff = region_height_r;
    end
  end

  // A scroll first copies the region into the shadow store, so every source is read as it
  // was before the scroll even where region cells share an address; cells are then
  // rewritten row by row, left to right.
  always_comb begin
    cur_r     = rcnt_r;
    cur_c     = ccnt_r;
    sr        = $signed({4'b0000, cur_r}) + 12'(vs_r);
    sc        = $signed({4'b0000, cur_c}) + 12'(hs_r);
    src_in    = !fill_r && !sr[11] && (sr < $signed({4'b0000, h_eff}))
                && !sc[11] && (sc < $signed({4'b0000, w_eff}));
    dst_addr  = cell_addr(origin_row_r, cur_r, row_pitch_r, origin_column_r, cur_c);
    src_addr  = cell_addr(origin_row_r, sr[7:0], row_pitch_r, origin_column_r, sc[7:0]);
    cur_addr  = cell_addr(origin_row_r, 8'(cursor_row_r), row_pitch_r, origin_column_r,
                          8'(cursor_col_r));
    cell_last = (rcnt_r == h_eff - 8'd1) && (ccnt_r == w_eff - 8'd1);
  end

  always_comb begin
    if (x_r[9]) begin
      nx = '0;
      ny = 11'(y_r);
    end else if (x_r >= $signed({2'b00, w_eff})) begin
      nx = '0;
      ny = 11'(y_r) + 11'sd1;
    end else begin
      nx = x_r;
      ny = 11'(y_r);
    end
    need_scroll = 1'b0;
    vs_new      = ny - $signed({3'b000, h_eff}) + 11'sd1;
    if (ny[10]) begin
      fy = '0;
    end else if (ny >= $signed({3'b000, h_eff})) begin
      fy          = 7'(h_eff - 8'd1);
      need_scroll = 1'b1;
    end else begin
      fy = ny[6:0];
    end
  end

  assign stat.place_scroll = need_scroll;
  assign stat.cell_last    = cell_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pitch_r     <= 8'd80;
      origin_column_r <= 7'd0;
      origin_row_r    <= 7'd0;
      region_width_r  <= 8'd80;
      region_height_r <= 8'd60;
      attribute_r     <= 8'd116;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcre_pkg::CFG_ROW_PITCH:     row_pitch_r     <= cfg_data;
        tcre_pkg::CFG_ORIGIN_COLUMN: origin_column_r <= cfg_data[6:0];
        tcre_pkg::CFG_ORIGIN_ROW:    origin_row_r    <= cfg_data[6:0];
        tcre_pkg::CFG_REGION_WIDTH:  region_width_r  <= cfg_data;
        tcre_pkg::CFG_REGION_HEIGHT: region_height_r <= cfg_data;
        tcre_pkg::CFG_ATTRIBUTE:     attribute_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.place) begin
        cursor_col_r <= nx[6:0];
        cursor_row_r <= fy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_operation;
      char_r    <= in_character;
      rd_cell_r <= in_cell_address[AW-1:0];
      rcnt_r    <= '0;
      ccnt_r    <= '0;
      fill_r    <= (in_operation == tcre_pkg::OP_FILL);
      if (in_operation == tcre_pkg::OP_FILL) begin
        hs_r <= '0;
        vs_r <= '0;
      end else begin
        hs_r <= 9'(in_shift_columns);
        vs_r <= 11'(in_shift_rows);
      end
      if (in_operation == tcre_pkg::OP_PUT) begin
        x_r <= $signed({3'b000, cursor_col_r}) + 10'sd1;
        y_r <= $signed({3'b000, cursor_row_r});
      end else begin
        x_r <= 10'(in_column);
        y_r <= 10'(in_row);
      end
    end else if (cmd.place) begin
      hs_r   <= '0;
      vs_r   <= vs_new;
      fill_r <= 1'b0;
    end
    if (cmd.cell_adr) begin
      dst_addr_r <= dst_addr;
      src_addr_r <= src_addr;
      src_in_r   <= src_in;
    end
    if (cmd.copy_wr || cmd.cell_wr) begin
      if (cell_last) begin
        ccnt_r <= '0;
        rcnt_r <= '0;
      end else if (ccnt_r == w_eff - 8'd1) begin
        ccnt_r <= '0;
        rcnt_r <= rcnt_r + 8'd1;
      end else begin
        ccnt_r <= ccnt_r + 8'd1;
      end
    end
    if (cmd.finish) begin
      out_col_r <= cursor_col_r;
      out_row_r <= cursor_row_r;
      out_rc_r  <= (op_r == tcre_pkg::OP_READ) ? rd_char_r : 8'd0;
      out_ra_r  <= (op_r == tcre_pkg::OP_READ) ? rd_attr_r : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd || cmd.read_rd) begin
      rd_char_r <= char_mem[cmd.read_rd ? rd_cell_r : dst_addr_r];
      rd_attr_r <= attr_mem[cmd.read_rd ? rd_cell_r : dst_addr_r];
    end
    if (cmd.put_wr) begin
      char_mem[cur_addr] <= char_r;
      attr_mem[cur_addr] <= attribute_r;
    end else if (cmd.cell_wr) begin
      char_mem[dst_addr_r] <= src_in_r ? sh_char_r : (fill_r ? char_r : tcre_pkg::BLANK_CHAR);
      attr_mem[dst_addr_r] <= src_in_r ? sh_attr_r : attribute_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_rd) begin
      sh_char_r <= shadow_char[src_addr_r];
      sh_attr_r <= shadow_attr[src_addr_r];
    end
    if (cmd.copy_wr) begin
      shadow_char[dst_addr_r] <= rd_char_r;
      shadow_attr[dst_addr_r] <= rd_attr_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_column  = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_read_character = out_rc_r;
  assign out_read_attribute = out_ra_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("Result strobe lasted more than one cycle.");

endmodule

### rtl/text_console_region_engine_unit.sv
// Top level of the text console region engine.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; its single result appears on the
// out_ ports for one cycle with out_valid and cannot be held off. A fill walks the region
// once through the single-port cell stores with an address, a read and a write step per
// region cell. A scroll first copies the region into a shadow store and then rewrites it,
// two walks of those steps per cell; a put or set that moves the cursor past the last row
// adds the same two walks. Configuration writes are taken while busy is low. The stores
// come up undefined and need no clearing after reset.
module text_console_region_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_operation,
  input  logic [7:0]        in_character,
  input  logic signed [8:0] in_column,
  input  logic signed [8:0] in_row,
  input  logic signed [7:0] in_shift_columns,
  input  logic signed [7:0] in_shift_rows,
  input  logic [12:0]       in_cell_address,
  output logic              out_valid,
  output logic [6:0]        out_cursor_column,
  output logic [6:0]        out_cursor_row,
  output logic [7:0]        out_read_character,
  output logic [7:0]        out_read_attribute,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  tcre_pkg::ctl_cmd_t cmd;
  tcre_pkg::dp_stat_t stat;

  assign cfg_ready = !busy;

  tcre_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  tcre_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_operation       (in_operation),
    .in_character       (in_character),
    .in_column          (in_column),
    .in_row             (in_row),
    .in_shift_columns   (in_shift_columns),
    .in_shift_rows      (in_shift_rows),
    .in_cell_address    (in_cell_address),
    .out_valid          (out_valid),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row),
    .out_read_character (out_read_character),
    .out_read_attribute (out_read_attribute)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for the text console region engine unit.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [2:0]        op;
    logic [7:0]        ch;
    logic signed [8:0] col;
    logic signed [8:0] row;
    logic signed [7:0] sh_c;
    logic signed [7:0] sh_r;
    logic [12:0]       addr;
  } req_t;

  typedef struct {
    logic [6:0] cur_col;
    logic [6:0] cur_row;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
  } cell_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_operation = '0;
  logic [7:0]        in_character = '0;
  logic signed [8:0] in_column = '0;
  logic signed [8:0] in_row = '0;
  logic signed [7:0] in_shift_columns = '0;
  logic signed [7:0] in_shift_rows = '0;
  logic [12:0]       in_cell_address = '0;
  logic              out_valid;
  logic [6:0]        out_cursor_column;
  logic [6:0]        out_cursor_row;
  logic [7:0]        out_read_character;
  logic [7:0]        out_read_attribute;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [7:0]        cfg_data = '0;

  text_console_region_engine_unit u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Console image and registers as the block should hold them.
  logic [7:0] char_mem [tcre_pkg::CELL_COUNT];
  logic [7:0] attr_mem [tcre_pkg::CELL_COUNT];
  logic [7:0] snap_char [tcre_pkg::MAX_SPAN*tcre_pkg::MAX_SPAN];
  logic [7:0] snap_attr [tcre_pkg::MAX_SPAN*tcre_pkg::MAX_SPAN];
  int cur_c, cur_r;
  int pitch, org_c, org_r, reg_w, reg_h, cur_attr;

  req_t         pending_reqs [$];
  cell_result_t expected_cells [$];
  bit           written [tcre_pkg::CELL_COUNT];
  int           written_list [$];
  int           mismatches, op_count [8], cfg_writes, results_seen;
  bit           quiet;
  int           gap;

  function automatic int span(int v);
    return (v < 1) ? 1 : (v > tcre_pkg::MAX_SPAN) ? tcre_pkg::MAX_SPAN : v;
  endfunction

  function automatic int cell_at(int r, int c);
    return ((org_r + r) * pitch + org_c + c) % tcre_pkg::CELL_COUNT;
  endfunction

  task automatic shift_region(int hs, int vs);
    int w, h, sr, sc, a;
    w = span(reg_w);
    h = span(reg_h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        a = cell_at(r, c);
        snap_char[r*w+c] = char_mem[a];
        snap_attr[r*w+c] = attr_mem[a];
      end
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        sr = r + vs;
        sc = c + hs;
        a = cell_at(r, c);
        if (sr >= 0 && sr < h && sc >= 0 && sc < w) begin
          char_mem[a] = snap_char[sr*w+sc];
          attr_mem[a] = snap_attr[sr*w+sc];
        end else begin
          char_mem[a] = tcre_pkg::BLANK_CHAR;
          attr_mem[a] = cur_attr[7:0];
        end
      end
  endtask

  task automatic move_cursor(int x, int y);
    int w, h;
    w = span(reg_w);
    h = span(reg_h);
    if (x < 0) x = 0;
    else if (x >= w) begin
      x = 0;
      y++;
    end
    if (y < 0) y = 0;
    else if (y >= h) begin
      shift_region(0, y - h + 1);
      y = h - 1;
    end
    cur_c = x;
    cur_r = y;
  endtask

  task automatic console_step(req_t q);
    cell_result_t e;
    int a;
    e.rd_char = '0;
    e.rd_attr = '0;
    op_count[q.op]++;
    case (q.op)
      tcre_pkg::OP_PUT: begin
        a = cell_at(cur_r, cur_c);
        char_mem[a] = q.ch;
        attr_mem[a] = cur_attr[7:0];
        move_cursor(cur_c + 1, cur_r);
      end
      tcre_pkg::OP_SET: move_cursor(int'(q.col), int'(q.row));
      tcre_pkg::OP_SCROLL: shift_region(int'(q.sh_c), int'(q.sh_r));
      tcre_pkg::OP_FILL: begin
        for (int r = 0; r < span(reg_h); r++)
          for (int c = 0; c < span(reg_w); c++) begin
            a = cell_at(r, c);
            char_mem[a] = q.ch;
            attr_mem[a] = cur_attr[7:0];
          end
      end
      tcre_pkg::OP_READ: begin
        e.rd_char = char_mem[q.addr];
        e.rd_attr = attr_mem[q.addr];
      end
      default: ;
    endcase
    e.cur_col = cur_c[6:0];
    e.cur_row = cur_r[6:0];
    expected_cells.push_back(e);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else if (!(start && busy)) begin
      int g;
      g = gap;
      if (start) begin
        console_step(pending_reqs.pop_front());
        g = 0;
        if (!quiet) begin
          case ($urandom_range(0, 9))
            0, 1, 2: g = $urandom_range(1, 3);
            3: g = $urandom_range(5, 40);
            default: g = 0;
          endcase
        end
      end
      if (g > 0) begin
        start <= 1'b0;
        gap <= g - 1;
      end else if (pending_reqs.size() > 0) begin
        start <= 1'b1;
        gap <= 0;
        in_operation <= pending_reqs[0].op;
        in_character <= pending_reqs[0].ch;
        in_column <= pending_reqs[0].col;
        in_row <= pending_reqs[0].row;
        in_shift_columns <= pending_reqs[0].sh_c;
        in_shift_rows <= pending_reqs[0].sh_r;
        in_cell_address <= pending_reqs[0].addr;
      end else begin
        start <= 1'b0;
        gap <= 0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      cell_result_t e;
      results_seen++;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result col=%0d row=%0d char=%h attr=%h",
                   out_cursor_column, out_cursor_row, out_read_character,
                   out_read_attribute);
      end else begin
        e = expected_cells.pop_front();
        if (out_cursor_column !== e.cur_col || out_cursor_row !== e.cur_row ||
            out_read_character !== e.rd_char || out_read_attribute !== e.rd_attr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected col=%0d row=%0d char=%h attr=%h, got col=%0d row=%0d char=%h attr=%h",
                     results_seen, e.cur_col, e.cur_row, e.rd_char, e.rd_attr,
                     out_cursor_column, out_cursor_row, out_read_character,
                     out_read_attribute);
        end
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || expected_cells.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      tcre_pkg::CFG_ROW_PITCH:     pitch = int'(val);
      tcre_pkg::CFG_ORIGIN_COLUMN: org_c = int'(val[6:0]);
      tcre_pkg::CFG_ORIGIN_ROW:    org_r = int'(val[6:0]);
      tcre_pkg::CFG_REGION_WIDTH:  reg_w = int'(val);
      tcre_pkg::CFG_REGION_HEIGHT: reg_h = int'(val);
      tcre_pkg::CFG_ATTRIBUTE:     cur_attr = int'(val);
      default: ;
    endcase
  endtask

  task automatic configure(int p, int oc, int orw, int w, int h, int at);
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(tcre_pkg::CFG_ROW_PITCH, p[7:0]);
    write_reg(tcre_pkg::CFG_ORIGIN_COLUMN, oc[7:0]);
    write_reg(tcre_pkg::CFG_ORIGIN_ROW, orw[7:0]);
    write_reg(tcre_pkg::CFG_REGION_WIDTH, w[7:0]);
    write_reg(tcre_pkg::CFG_REGION_HEIGHT, h[7:0]);
    write_reg(tcre_pkg::CFG_ATTRIBUTE, at[7:0]);
  endtask

  // Queues a request; a fill marks its cells as safe to read back.
  task automatic send(logic [2:0] op, logic [7:0] ch = 0, int col = 0, int row = 0,
                      int sc = 0, int sr = 0, int addr = -1);
    req_t q;
    int a;
    q.op = op;
    q.ch = ch;
    q.col = 9'(col);
    q.row = 9'(row);
    q.sh_c = 8'(sc);
    q.sh_r = 8'(sr);
    q.addr = 13'((addr < 0) ? written_list[$urandom_range(0, written_list.size() - 1)] : addr);
    if (op == tcre_pkg::OP_FILL)
      for (int r = 0; r < span(reg_h); r++)
        for (int c = 0; c < span(reg_w); c++) begin
          a = cell_at(r, c);
          if (!written[a]) begin
            written[a] = 1'b1;
            written_list.push_back(a);
          end
        end
    pending_reqs.push_back(q);
  endtask

  task automatic random_request();
    int w, h;
    w = span(reg_w);
    h = span(reg_h);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: send(tcre_pkg::OP_PUT, 8'($urandom));
      7, 8, 9:
        if ($urandom_range(0, 1))
          send(tcre_pkg::OP_SET, 0, $urandom_range(0, w + 3) - 2,
               $urandom_range(0, h + 3) - 2);
        else
          send(tcre_pkg::OP_SET, 0, $signed($urandom_range(0, 511) - 256),
               $signed($urandom_range(0, 511) - 256));
      10, 11:
        if ($urandom_range(0, 2) != 0)
          send(tcre_pkg::OP_SCROLL, 0, 0, 0, $urandom_range(0, 2*w + 2) - w - 1,
               $urandom_range(0, 2*h + 2) - h - 1);
        else
          send(tcre_pkg::OP_SCROLL, 0, 0, 0, $urandom_range(0, 255) - 128,
               $urandom_range(0, 255) - 128);
      12: send(tcre_pkg::OP_FILL, 8'($urandom));
      13: send(3'($urandom_range(5, 7)), 8'($urandom), 0, 0, 0, 0, $urandom_range(0, 8191));
      default: send(tcre_pkg::OP_READ);
    endcase
  endtask

  initial begin
    int w, h;
    pitch = 80; org_c = 0; org_r = 0; reg_w = 80; reg_h = 60; cur_attr = 116;
    cur_c = 0; cur_r = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, including a put that wraps and scrolls the full screen.
    send(tcre_pkg::OP_FILL, "a");
    send(tcre_pkg::OP_PUT, 8'h00);
    send(tcre_pkg::OP_READ);
    send(tcre_pkg::OP_SET, 0, 79, 59);
    send(tcre_pkg::OP_PUT, 8'hff);
    send(tcre_pkg::OP_READ);

    configure(16, 3, 2, 6, 4, 8'ha5);
    send(tcre_pkg::OP_FILL, "b");
    send(tcre_pkg::OP_PUT, 8'h00);
    send(tcre_pkg::OP_PUT, 8'hff);
    send(tcre_pkg::OP_SET, 0, -256, -256);
    send(tcre_pkg::OP_SET, 0, 255, 255);
    send(tcre_pkg::OP_SET, 0, 5, 3);
    send(tcre_pkg::OP_PUT, "c");
    send(tcre_pkg::OP_SCROLL, 0, 0, 0, 1, 1);
    send(tcre_pkg::OP_SCROLL, 0, 0, 0, -1, -2);
    send(tcre_pkg::OP_SCROLL, 0, 0, 0, 127, 0);
    send(tcre_pkg::OP_SCROLL, 0, 0, 0, -128, -128);
    send(3'd5, 0, 0, 0, 0, 0, 0);
    send(3'd6, 0, 0, 0, 0, 0, 8191);
    send(3'd7);
    send(tcre_pkg::OP_READ);
    send(tcre_pkg::OP_READ);
    send(tcre_pkg::OP_FILL, "z");
    send(tcre_pkg::OP_READ);

    // Zero sizes act as 1; the cursor is now stale.
    configure(0, 127, 127, 0, 0, 8'h00);
    send(tcre_pkg::OP_FILL, "d");
    send(tcre_pkg::OP_PUT, "e");
    send(tcre_pkg::OP_PUT, "f");
    send(tcre_pkg::OP_READ);

    // Largest region, reaching every cell address.
    configure(128, 127, 127, 128, 128, 8'hff);
    send(tcre_pkg::OP_FILL, "g");
    send(tcre_pkg::OP_SCROLL, 0, 0, 0, 3, -2);
    send(tcre_pkg::OP_SET, 0, -5, 300);
    send(tcre_pkg::OP_PUT, "h");
    for (int i = 0; i < 6; i++) send(tcre_pkg::OP_READ);

    configure(255, 0, 0, 255, 1, 8'h5a);
    send(tcre_pkg::OP_FILL, "i");
    for (int i = 0; i < 10; i++) random_request();

    for (int ph = 0; ph < 22; ph++) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 7))
        0: w = 0;
        1: h = $urandom_range(9, 12);
        2: begin w = $urandom_range(20, 128); h = 1; end
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: configure(0, $urandom_range(0, 127), $urandom_range(0, 127), w, h, $urandom);
        1: configure(255, $urandom_range(0, 127), $urandom_range(0, 127), w, h, $urandom);
        2: configure(128, $urandom_range(0, 127), $urandom_range(0, 127), w, h, $urandom);
        default: configure($urandom_range(1, 32), $urandom_range(0, 127),
                           $urandom_range(0, 127), w, h, $urandom);
      endcase
      quiet = (ph % 4 == 3);
      send(tcre_pkg::OP_FILL, 8'($urandom));
      for (int i = 0; i < 42; i++) random_request();
      if (ph % 3 == 0) begin
        wait_drained();
      end
      for (int i = 0; i < 42; i++) random_request();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d puts, %0d cursor sets, %0d scrolls, %0d fills, %0d reads,",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
    $display("%0d unused codes, %0d register writes, %0d results checked.",
             op_count[5] + op_count[6] + op_count[7], cfg_writes, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/tcre_pkg.sv
rtl/tcre_ctrl.sv
rtl/tcre_dpath.sv
rtl/text_console_region_engine_unit.sv
sim/testbench.sv
